### design/ipv4_tcp_ingress_header_checker_unit_macros.svh
// ----------------------------------------------------------------------------
// IPv4/TCP ingress header checker assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IPV4_TCP_INGRESS_HEADER_CHECKER_UNIT_MACROS_SVH
`define IPV4_TCP_INGRESS_HEADER_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ITHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ithc assertion failed");

// next-cycle implication
`define ITHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ithc assertion failed");

`else

`define ITHC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ITHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/ithc_pkg.sv
// ----------------------------------------------------------------------------
// ithc_pkg
// Shared types and constants of the IPv4/TCP ingress header checker.
// ----------------------------------------------------------------------------
package ithc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CSUM    = 2'd1,
    ST_TTL_EXPIRED = 2'd2,
    ST_MALFORMED   = 2'd3
  } status_t;

  localparam logic [15:0] SUM_ALL_ONES = 16'hffff;
  localparam logic [15:0] IDX_SAT      = 16'hffff;
  localparam logic [3:0]  IHL_MIN      = 4'd5;
  localparam logic [5:0]  FLAG_MASK    = 6'h3f;
  localparam logic [15:0] TCP_MIN_SPAN = 16'd14;

  // queue between parser and result stage
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  ttl_left;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [6:0]  header_bytes;
    logic [5:0]  tcp_flags;
    logic [15:0] total_length;
  } out_item_t;

  // per-packet record handed from parser to result stage
  typedef struct packed {
    logic        malformed;
    logic        sum_ok;
    logic [3:0]  ip_words;
    logic [3:0]  tcp_words;
    logic [7:0]  ttl;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [5:0]  flags;
    logic [15:0] length;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### design/ithc_front.sv
// ----------------------------------------------------------------------------
// ithc_front
// Byte parser: counts bytes, sums the IP header, captures header fields and
// pushes one record per packet on the last byte.
// ----------------------------------------------------------------------------
module ithc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  ithc_pkg::in_item_t in_item,
  output logic              push,
  output ithc_pkg::rec_t    push_rec
);

  logic [15:0] idx_r, idx_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] ack_r, ack_nxt;
  logic [3:0]  tcpw_r, tcpw_nxt;
  logic [5:0]  flags_r, flags_nxt;

  logic [7:0]  b;
  logic [5:0]  hdr;
  logic        in_hdr;
  logic [15:0] rel;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;

  assign b = in_item.packet_byte;

  // field capture for the current byte
  always_comb begin
    ihl_nxt   = (idx_r == 16'd0) ? b[3:0] : ihl_r;
    hdr       = {ihl_nxt, 2'b00};
    in_hdr    = idx_r < {10'd0, hdr};
    rel       = idx_r - {10'd0, hdr};
    sum_wide  = {1'b0, sum_r} + {1'b0, hold_r, b};
    sum_fold  = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];

    hold_nxt  = hold_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    ttl_nxt   = ttl_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    tcpw_nxt  = tcpw_r;
    flags_nxt = flags_r;

    // ones'-complement sum over header words
    if (in_hdr) begin
      if (!idx_r[0]) begin
        hold_nxt = b;
      end else begin
        sum_nxt = sum_fold;
      end
    end

    if (idx_r == 16'd2) begin
      len_nxt = {b, len_r[7:0]};
    end else if (idx_r == 16'd3) begin
      len_nxt = {len_r[15:8], b};
    end else if (idx_r == 16'd8) begin
      ttl_nxt = b;
    end

    // TCP header fields, offset from end of IP header
    if (!in_hdr) begin
      if (rel >= 16'd4 && rel <= 16'd7) begin
        seq_nxt = {seq_r[23:0], b};
      end else if (rel >= 16'd8 && rel <= 16'd11) begin
        ack_nxt = {ack_r[23:0], b};
      end else if (rel == 16'd12) begin
        tcpw_nxt = b[7:4];
      end else if (rel == 16'd13) begin
        flags_nxt = b[5:0] & ithc_pkg::FLAG_MASK;
      end
    end

    idx_nxt = (idx_r != ithc_pkg::IDX_SAT) ? (idx_r + 16'd1) : idx_r;
  end

  // record for the result stage
  always_comb begin
    push               = acc && in_item.last_byte;
    push_rec.malformed = (ihl_nxt < ithc_pkg::IHL_MIN) ||
                         (idx_nxt < ({10'd0, hdr} + ithc_pkg::TCP_MIN_SPAN));
    push_rec.sum_ok    = (sum_nxt == ithc_pkg::SUM_ALL_ONES);
    push_rec.ip_words  = ihl_nxt;
    push_rec.tcp_words = tcpw_nxt;
    push_rec.ttl       = ttl_nxt;
    push_rec.seq       = seq_nxt;
    push_rec.ack       = ack_nxt;
    push_rec.flags     = flags_nxt;
    push_rec.length    = len_nxt;
  end

  // parse state; cleared after every last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_item.last_byte)) begin
      idx_r   <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      ihl_r   <= '0;
      ttl_r   <= '0;
      len_r   <= '0;
      seq_r   <= '0;
      ack_r   <= '0;
      tcpw_r  <= '0;
      flags_r <= '0;
    end else if (acc) begin
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      ihl_r   <= ihl_nxt;
      ttl_r   <= ttl_nxt;
      len_r   <= len_nxt;
      seq_r   <= seq_nxt;
      ack_r   <= ack_nxt;
      tcpw_r  <= tcpw_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

### design/ithc_queue.sv
// ----------------------------------------------------------------------------
// ithc_queue
// Short FIFO of packet records between the parser and the result stage.
// ----------------------------------------------------------------------------
module ithc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ithc_pkg::rec_t     push_rec,
  input  logic               pop,
  output ithc_pkg::rec_t     pop_rec,
  output ithc_pkg::q_stat_t  stat
);

  ithc_pkg::rec_t mem_r [ithc_pkg::QDEPTH];

  logic [ithc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ithc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ithc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [ithc_pkg::QPTR_W-1:0] PTR_LAST = ithc_pkg::QPTR_W'(ithc_pkg::QDEPTH - 1);
  localparam logic [ithc_pkg::QCNT_W-1:0] CNT_FULL = ithc_pkg::QCNT_W'(ithc_pkg::QDEPTH);

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign pop_rec    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

### design/ithc_back.sv
// ----------------------------------------------------------------------------
// ithc_back
// Result stage: turns a packet record into status and reported fields and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module ithc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ithc_pkg::q_stat_t   stat,
  input  ithc_pkg::rec_t      rec,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ithc_pkg::out_item_t out_item
);

  logic                valid_r, valid_nxt;
  ithc_pkg::out_item_t res_r, res_nxt;
  logic [4:0]          words_sum;

  assign pop       = !stat.empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_item  = res_r;

  // status priority: malformed, checksum, ttl
  always_comb begin
    words_sum = {1'b0, rec.ip_words} + {1'b0, rec.tcp_words};
    res_nxt   = '0;
    if (rec.malformed) begin
      res_nxt.status = ithc_pkg::ST_MALFORMED;
    end else begin
      priority if (!rec.sum_ok) begin
        res_nxt.status = ithc_pkg::ST_BAD_CSUM;
      end else if (rec.ttl <= 8'd1) begin
        res_nxt.status = ithc_pkg::ST_TTL_EXPIRED;
      end else begin
        res_nxt.status = ithc_pkg::ST_OK;
      end
      res_nxt.ttl_left     = rec.ttl - 8'd1;
      res_nxt.seq_number   = rec.seq;
      res_nxt.ack_number   = rec.ack;
      res_nxt.header_bytes = {words_sum, 2'b00};
      res_nxt.tcp_flags    = rec.flags;
      res_nxt.total_length = rec.length;
    end
  end

  // output valid
  always_comb begin
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

### design/ipv4_tcp_ingress_header_checker_unit.sv
// ----------------------------------------------------------------------------
// ipv4_tcp_ingress_header_checker_unit
// Byte-serial IPv4 header checksum check and TCP header field extraction.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; one result per packet on its last byte.
// Result path: when the last byte is accepted its record is written to the
//   record queue, then popped into the output register (out_valid).
// Input stalls only when the two-entry record queue is full.
// Reset (synchronous, rst_n low) clears the parse state, queue and out_valid.
`include "ipv4_tcp_ingress_header_checker_unit_macros.svh"

module ipv4_tcp_ingress_header_checker_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ithc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ithc_pkg::out_item_t out_item
);

  logic              acc;
  logic              push;
  logic              pop;
  ithc_pkg::rec_t    push_rec;
  ithc_pkg::rec_t    pop_rec;
  ithc_pkg::q_stat_t q_stat;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;

  ithc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_item  (in_item),
    .push     (push),
    .push_rec (push_rec)
  );

  ithc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .stat     (q_stat)
  );

  ithc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (q_stat),
    .rec       (pop_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a packet end always leaves a record queued
  `ITHC_ASSERT_NEXT(a_push_queued, clk, rst_n, push, !q_stat.empty)
  // results are only taken from a filled queue
  `ITHC_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, !q_stat.empty)
  // a malformed result reports zero fields
  `ITHC_ASSERT_IMPL(a_malformed_zero, clk, rst_n,
    out_valid && (out_item.status == ithc_pkg::ST_MALFORMED),
    (out_item.ttl_left == 8'd0) && (out_item.seq_number == 32'd0) &&
    (out_item.header_bytes == 7'd0) && (out_item.total_length == 16'd0))

endmodule
